/* rtl/swm_pkg.sv */
`default_nettype none

package swm_pkg;

    // Configuration register: window size, 5 bits, reset value 15.
    localparam int CFG_W     = 5;
    localparam int CFG_RESET = 15;

    localparam int DEF_MAX_WINDOW   = 16;
    localparam int DEF_SAMPLE_WIDTH = 16;

endpackage

`default_nettype wire

/* rtl/swm_cell.sv */
`default_nettype none

module swm_cell #(
    parameter int SW = 16,
    parameter int AW = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wire                 i_clear,
    input  wire                 i_full,
    input  wire [AW-1:0]        i_oldest,
    input  wire signed [SW-1:0] i_sample,
    input  wire                 i_nxt_valid,
    input  wire [AW-1:0]        i_nxt_age,
    input  wire signed [SW-1:0] i_nxt_value,
    input  wire                 i_prv_c_valid,
    input  wire [AW-1:0]        i_prv_c_age,
    input  wire signed [SW-1:0] i_prv_c_value,
    input  wire                 i_prv_gt,
    input  wire                 i_chain,
    output logic                o_valid,
    output logic [AW-1:0]       o_age,
    output logic signed [SW-1:0] o_value,
    output logic                o_c_valid,
    output logic [AW-1:0]       o_c_age,
    output logic signed [SW-1:0] o_c_value,
    output logic                o_gt,
    output logic                o_chain
);

    logic                 r_valid;
    logic [AW-1:0]        r_age;
    logic signed [SW-1:0] r_value;
    logic                 n_valid;
    logic [AW-1:0]        n_age;
    logic signed [SW-1:0] n_value;
    logic                 w_del;

    // The oldest entry leaves when the window is full; every entry above it
    // closes the gap by taking its upper neighbor.
    assign w_del   = r_valid && i_full && (r_age == i_oldest);
    assign o_chain = i_chain || w_del;

    assign o_c_valid = o_chain ? i_nxt_valid : r_valid;
    assign o_c_age   = o_chain ? i_nxt_age   : r_age;
    assign o_c_value = o_chain ? i_nxt_value : r_value;

    // Empty slots count as greater so the new sample lands at the first one.
    assign o_gt = !o_c_valid || (o_c_value > i_sample);

    always_comb begin
        if (!o_gt) begin
            n_valid = o_c_valid;
            n_age   = o_c_age + 1'b1;
            n_value = o_c_value;
        end else if (!i_prv_gt) begin
            n_valid = 1'b1;
            n_age   = '0;
            n_value = i_sample;
        end else begin
            n_valid = i_prv_c_valid;
            n_age   = i_prv_c_age + 1'b1;
            n_value = i_prv_c_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_age   <= n_age;
            r_value <= n_value;
        end
    end

    assign o_valid = r_valid;
    assign o_age   = r_age;
    assign o_value = r_value;

endmodule

`default_nettype wire

/* rtl/sliding_window_median.sv */
`default_nettype none

// Running median over the most recent N signed samples, where N is the
// configured window size.
// Input channel: i_in_valid / o_in_stall carry one sample per beat on i_sample.
// Output channel: o_out_valid / i_out_stall carry one median per beat on o_median.
// Every accepted sample gives exactly one median, in order.
// An accepted sample enters the sorted cell row, and its median is registered on
// o_median from that row once the output register is free.
// Throughput is one sample per cycle while the receiver does not stall: the
// sorted cell row inserts the new sample and, once the window is full, evicts
// the oldest one in the same update; the median is then picked from the row.
// While the receiver stalls, the output beat holds, one more sample may be
// accepted and its result waits in the cell row; then o_in_stall rises until
// the output moves on.
// Writing the window size (i_cfg_we, i_cfg_data) clears the history; warm-up
// medians are taken over the samples received since the clear. A size of zero
// acts as one and sizes above MAX_WINDOW act as MAX_WINDOW.
// Reset sets the window size to min(15, MAX_WINDOW), empties the history and drops o_out_valid.
module sliding_window_median #(
    parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [swm_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_median
);

    import swm_pkg::*;

    localparam int M  = MAX_WINDOW;
    localparam int SW = SAMPLE_WIDTH;
    localparam int NW = $clog2(M + 1);
    localparam int AW = (M > 1) ? $clog2(M) : 1;
    localparam int RST_SIZE = (CFG_RESET > M) ? M : CFG_RESET;

    logic [NW-1:0] r_size;
    logic [NW-1:0] r_count;
    logic          r_pend;
    logic [AW-1:0] r_pick;
    logic          r_out_valid;
    logic signed [SW-1:0] r_median;

    logic [NW-1:0] n_size;
    logic [AW-1:0] n_pick;
    logic          w_full;
    logic          w_accept;
    logic          w_out_free;
    logic [NW:0]   w_count_inc;

    logic                 w_vld   [M];
    logic [AW-1:0]        w_age   [M];
    logic signed [SW-1:0] w_val   [M];
    logic                 w_cvld  [M];
    logic [AW-1:0]        w_cage  [M];
    logic signed [SW-1:0] w_cval  [M];
    logic                 w_gt    [M];
    logic                 w_chain [M];

    always_comb begin
        if (i_cfg_data == '0) begin
            n_size = NW'(1);
        end else if (32'(i_cfg_data) > 32'(M)) begin
            n_size = NW'(M);
        end else begin
            n_size = NW'(i_cfg_data);
        end
    end

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_pend && !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == r_size);
    assign w_count_inc = {1'b0, r_count} + 1'b1;

    // The window counts as filled on the sample that completes it.
    always_comb begin
        if (w_count_inc >= {1'b0, r_size}) begin
            n_pick = AW'(r_size >> 1);
        end else begin
            n_pick = AW'(r_count >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= NW'(RST_SIZE);
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size  <= n_size;
                r_count <= '0;
            end else if (w_accept && !w_full) begin
                r_count <= w_count_inc[NW-1:0];
            end
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_out_free) begin
                r_pend <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_pend;
            end
        end
        if (w_accept) begin
            r_pick <= n_pick;
        end
        if (w_out_free && r_pend) begin
            r_median <= w_val[r_pick];
        end
    end

    for (genvar g = 0; g < M; g++) begin : g_cell
        logic                 w_nxt_vld;
        logic [AW-1:0]        w_nxt_age;
        logic signed [SW-1:0] w_nxt_val;
        logic                 w_prv_cvld;
        logic [AW-1:0]        w_prv_cage;
        logic signed [SW-1:0] w_prv_cval;
        logic                 w_prv_gt;
        logic                 w_prv_chain;

        if (g == M - 1) begin : g_top
            assign w_nxt_vld = 1'b0;
            assign w_nxt_age = '0;
            assign w_nxt_val = '0;
        end else begin : g_mid
            assign w_nxt_vld = w_vld[g+1];
            assign w_nxt_age = w_age[g+1];
            assign w_nxt_val = w_val[g+1];
        end

        if (g == 0) begin : g_bot
            assign w_prv_cvld  = 1'b0;
            assign w_prv_cage  = '0;
            assign w_prv_cval  = '0;
            assign w_prv_gt    = 1'b0;
            assign w_prv_chain = 1'b0;
        end else begin : g_low
            assign w_prv_cvld  = w_cvld[g-1];
            assign w_prv_cage  = w_cage[g-1];
            assign w_prv_cval  = w_cval[g-1];
            assign w_prv_gt    = w_gt[g-1];
            assign w_prv_chain = w_chain[g-1];
        end

        swm_cell #(
            .SW(SW),
            .AW(AW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_load        (w_accept && !i_cfg_we),
            .i_clear       (i_cfg_we),
            .i_full        (w_full),
            .i_oldest      (AW'(r_size - 1'b1)),
            .i_sample      (i_sample),
            .i_nxt_valid   (w_nxt_vld),
            .i_nxt_age     (w_nxt_age),
            .i_nxt_value   (w_nxt_val),
            .i_prv_c_valid (w_prv_cvld),
            .i_prv_c_age   (w_prv_cage),
            .i_prv_c_value (w_prv_cval),
            .i_prv_gt      (w_prv_gt),
            .i_chain       (w_prv_chain),
            .o_valid       (w_vld[g]),
            .o_age         (w_age[g]),
            .o_value       (w_val[g]),
            .o_c_valid     (w_cvld[g]),
            .o_c_age       (w_cage[g]),
            .o_c_value     (w_cval[g]),
            .o_gt          (w_gt[g]),
            .o_chain       (w_chain[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;

endmodule

`default_nettype wire

/* rtl/swm_checker.sv */
`default_nettype none

module swm_checker #(
    parameter int SW = 16
) (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input wire signed [SW-1:0] o_median
);

    // The input side only backs up when a result is stuck behind the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output can move");

    // Every accepted sample is followed by o_out_valid after the cell row and output register.
    a_result_arrives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> ##1 o_out_valid)
        else $error("accepted sample produced no result");

    // A pending result is never dropped without a beat.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(o_out_valid)) |-> $past(!i_out_stall))
        else $error("result dropped without a beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_median)))
        else $error("stalled result changed");

endmodule

bind sliding_window_median swm_checker #(
    .SW(SAMPLE_WIDTH)
) u_swm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_median    (o_median)
);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import swm_pkg::*;

    localparam int SAMPLE_W     = DEF_SAMPLE_WIDTH;
    localparam int MAX_WIN      = DEF_MAX_WINDOW;
    localparam int IDLE_PCT     = 19;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 200;
    localparam int STUCK_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 1200;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_cfg_we   = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    sample_t             i_sample   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    sample_t             o_median;

    sliding_window_median dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_median    (o_median)
    );

    sample_t pending_samples[$];
    sample_t expected_medians[$];
    sample_t observed_medians[$];
    int      err_count = 0;

    // Stimulus phase flags, changed only at the falling edge.
    bit      hold_armed = 1'b0;
    bit      no_idle    = 1'b0;

    // Predicted filter state.
    logic [CFG_W-1:0] win_size = CFG_W'(CFG_RESET);
    int               wr_pos   = 0;
    bit               win_full = 1'b0;
    sample_t          win_buf [MAX_WIN] = '{default: '0};

    // Stores the sample in the circular window and returns the median the
    // block must produce for it.
    function automatic sample_t push_and_median(input sample_t s);
        sample_t sorted [MAX_WIN];
        sample_t key;
        int n, pos, count, pick, i, j;
        n = (win_size == 0) ? 1 : ((win_size > MAX_WIN) ? MAX_WIN : int'(win_size));
        pos = (wr_pos >= n) ? 0 : wr_pos;
        win_buf[pos] = s;
        if (pos == n - 1) begin
            win_full = 1'b1;
        end
        count = win_full ? n : pos + 1;
        pick  = win_full ? n / 2 : pos / 2;
        for (i = 0; i < count; i++) begin
            key = win_buf[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        wr_pos = (pos + 1) % n;
        return sorted[pick];
    endfunction

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Sender: a stalled beat holds; otherwise the next pending sample is
    // offered unless this cycle idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_medians.push_back(push_and_median(i_sample));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_in_valid <= 1'b1;
                    i_sample   <= pending_samples.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    bit hold_done = 1'b0;
    int hold_left = 0;

    // Receiver: collects median beats and stalls at random, once for a long
    // stretch so that the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                observed_medians.push_back(o_median);
            end
            if (hold_armed && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Comparison runs at the falling edge, after both sides of the rising edge
    // have settled, so a beat and its prediction never race.
    always @(negedge i_clk) begin
        if (observed_medians.size() != 0) begin
            if (expected_medians.size() == 0) begin
                $error("median: no beat expected, actual %0d", observed_medians[0]);
                err_count++;
            end else begin
                if (observed_medians[0] !== expected_medians[0]) begin
                    $error("median: expected %0d, actual %0d",
                           expected_medians[0], observed_medians[0]);
                    err_count++;
                end
                void'(expected_medians.pop_front());
            end
            void'(observed_medians.pop_front());
        end
    end

    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_samples.size() != 0 || i_in_valid ||
                   expected_medians.size() != 0 || observed_medians.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_size = value;
        wr_pos   = 0;
        win_full = 1'b0;
        @(negedge i_clk);
    endtask

    // Mix of full-range values, tight clusters that give many ties, and values
    // at or near both ends of the range.
    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return sample_t'($urandom);
        end else if (pick < 80) begin
            return sample_t'($urandom_range(0, 8) - 4);
        end else if (pick < 90) begin
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else begin
            return $urandom_range(0, 1) ? sample_t'(16'h7FFF - $urandom_range(0, 3))
                                        : sample_t'(16'h8000 + $urandom_range(0, 3));
        end
    endfunction

    initial begin
        int phase_sizes[$] = '{16, 1, 9, 0, 31, 17, 2};
        int total, ph, n;
        logic [CFG_W-1:0] size_value;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset window size, warm-up over the extremes and alternating bits.
        pending_samples = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1,
                            16'sh5555, 16'shAAAA};
        // Size zero acts as one.
        write_window(5'd0);
        pending_samples = '{16'sh8000, 16'sh7FFF};
        // Even size takes the upper median.
        write_window(5'd2);
        pending_samples = '{-16'sd5, 16'sd7, 16'sh8000};
        // Oversized value saturates to the largest window.
        write_window(5'd31);
        pending_samples = '{16'sd100, -16'sd100, 16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1};

        total = 0;
        ph = 0;
        while (total < RANDOM_ITEMS) begin
            if (ph < phase_sizes.size()) begin
                size_value = CFG_W'(phase_sizes[ph]);
            end else if ($urandom_range(0, 3) == 0) begin
                size_value = CFG_W'($urandom_range(0, 31));
            end else begin
                size_value = CFG_W'($urandom_range(1, MAX_WIN));
            end
            // Some phases keep the history and only let the sender drain.
            if (ph < phase_sizes.size() || $urandom_range(0, 3) != 0) begin
                write_window(size_value);
            end else begin
                wait_idle();
            end
            no_idle = (ph == 4);
            if (ph == 2) begin
                hold_armed = 1'b1;
            end
            n = (ph == 2 || ph == 4) ? 300 : $urandom_range(10, 120);
            repeat (n) pending_samples.push_back(random_sample());
            total += n;
            ph++;
        end

        wait_idle();
        if (err_count == 0 && expected_medians.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
